// ===== rtl/lcpc_pkg.sv =====
// Shared constants, widths and control types of the prefix counter unit.
`default_nettype none
package lcpc_pkg;

  localparam int MAX_PREFIX  = 64;
  localparam int INDEX_BITS  = 32;

  localparam int LEN_W       = 7;
  localparam int CNT_W       = 32;
  localparam int DEPTH_W     = $clog2(MAX_PREFIX + 1);
  localparam int ADDR_W      = $clog2(MAX_PREFIX);
  localparam int CMP_W       = (DEPTH_W > LEN_W) ? DEPTH_W : LEN_W;
  localparam int DIFF_W      = (INDEX_BITS + 1 > CNT_W + 1) ? INDEX_BITS + 1 : CNT_W + 1;

  localparam int IN_TDATA_W  = ((LEN_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = LEN_W + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64);

  localparam logic CMD_SUFFIX = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic load;
    logic rd;
    logic pop;
    logic fill;
    logic done;
  } lcpc_cmd_t;

  typedef struct packed {
    logic gt;
    logic lt;
    logic more;
    logic fill_end;
    logic eval_hold;
    logic done_hold;
    logic pend_valid;
  } lcpc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lcpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lcpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcpc_ctrl.sv =====
// Controller state machine sequencing pops, fills and result hand-off.
`default_nettype none
module lcpc_ctrl
  import lcpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  input  wire lcpc_stat_t stat,
  output lcpc_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_valid & s_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.gt) begin
          cmd.rd     = 1'b1;
          state_next = S_EVAL;
        end else if (stat.lt) begin
          state_next = S_FILL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVAL: begin
        if (!stat.eval_hold) begin
          cmd.pop    = 1'b1;
          state_next = stat.more ? S_EVAL : S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill   = 1'b1;
        state_next = stat.fill_end ? S_DONE : S_FILL;
      end
      S_DONE: begin
        if (!stat.done_hold) begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      s_ready <= 1'b0;
    end else begin
      state   <= state_next;
      s_ready <= (state_next == S_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CHECK)
    else $error("accepted request did not move to check");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !stat.pend_valid)
    else $error("pending result left behind at idle");

  a_fill_below: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> stat.lt)
    else $error("fill with stack already at target depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/lcpc_dp.sv =====
// Datapath: stack RAM, depth and position counters, result hold and output registers.
`default_nettype none
module lcpc_dp
  import lcpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata,
  input  wire logic             in_cmd,
  input  wire logic [LEN_W-1:0] in_len,
  input  wire logic             out_ready,
  input  wire lcpc_cmd_t        cmd,
  output lcpc_stat_t            stat,
  output logic                  out_valid,
  output logic [LEN_W-1:0]      out_len,
  output logic [CNT_W-1:0]      out_occ,
  output logic [CNT_W-1:0]      out_end,
  output logic                  out_last
);

  logic [LEN_W-1:0]      max_len;
  logic [INDEX_BITS-1:0] position;
  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    target;
  logic                  fin;
  logic                  first;
  logic                  pend_valid;
  logic [LEN_W-1:0]      pend_len;
  logic [CNT_W-1:0]      pend_occ;
  logic [CNT_W-1:0]      pend_end;

  logic [CMP_W-1:0]      len_c;
  logic [DEPTH_W-1:0]    target_next;
  logic [INDEX_BITS-1:0] rdata;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DEPTH_W-1:0]    depth_m1;
  logic [DEPTH_W-1:0]    depth_m2;
  logic [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]     pos_m1;
  logic [CNT_W-1:0]      occ;
  logic                  report;
  logic                  out_free;
  logic                  out_load;
  logic                  out_load_last;

  always_comb begin
    len_c = CMP_W'(in_len);
    if (len_c > CMP_W'(max_len)) begin
      len_c = CMP_W'(max_len);
    end
    if (len_c > CMP_W'(MAX_PREFIX)) begin
      len_c = CMP_W'(MAX_PREFIX);
    end
    target_next = (in_cmd == CMD_FINISH) ? '0 : DEPTH_W'(len_c);
  end

  assign depth_m1 = depth - DEPTH_W'(1);
  assign depth_m2 = depth - DEPTH_W'(2);
  assign rd_en    = cmd.rd | (cmd.pop & stat.more);
  assign rd_addr  = cmd.rd ? depth_m1[ADDR_W-1:0] : depth_m2[ADDR_W-1:0];

  lcpc_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (MAX_PREFIX)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.fill),
    .waddr (depth[ADDR_W-1:0]),
    .wdata (position),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign diff   = DIFF_W'(position) - DIFF_W'(rdata) + DIFF_W'(1);
  assign pos_m1 = DIFF_W'(position) - DIFF_W'(1);
  assign occ    = (|diff[DIFF_W-1:CNT_W]) ? '1 : diff[CNT_W-1:0];
  assign report = first | (diff > DIFF_W'(2));

  assign out_free = ~out_valid | out_ready;

  always_comb begin
    stat.gt         = depth > target;
    stat.lt         = depth < target;
    stat.more       = {1'b0, depth} > ({1'b0, target} + (DEPTH_W + 1)'(1));
    stat.fill_end   = ({1'b0, depth} + (DEPTH_W + 1)'(1)) == {1'b0, target};
    stat.eval_hold  = report & pend_valid & ~out_free;
    stat.done_hold  = pend_valid & ~out_free;
    stat.pend_valid = pend_valid;
  end

  assign out_load      = (cmd.pop & report & pend_valid) | (cmd.done & pend_valid);
  assign out_load_last = cmd.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len    <= MAX_LEN_RESET;
      position   <= '0;
      depth      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (cmd.pop) begin
        depth <= depth_m1;
        if (report) begin
          pend_valid <= 1'b1;
        end
      end
      if (cmd.fill) begin
        depth <= depth + DEPTH_W'(1);
      end
      if (cmd.done) begin
        pend_valid <= 1'b0;
        if (fin) begin
          position <= '0;
        end else if (position != '1) begin
          position <= position + INDEX_BITS'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_next;
      fin    <= in_cmd;
      first  <= 1'b1;
    end
    if (cmd.pop) begin
      first <= 1'b0;
      if (report) begin
        pend_len <= LEN_W'(depth);
        pend_occ <= occ;
        pend_end <= pos_m1[CNT_W-1:0];
      end
    end
    if (out_load) begin
      out_len  <= pend_len;
      out_occ  <= pend_occ;
      out_end  <= pend_end;
      out_last <= out_load_last;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_PREFIX))
    else $error("stack depth beyond capacity");

  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && report && pend_valid |-> out_free)
    else $error("held result overwritten while output busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> depth > target)
    else $error("pop at or below target depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/lcp_interval_prefix_counter_unit.sv =====
// Top level of the LCP interval prefix counter: stream ports, controller and datapath.
`default_nettype none
// Each request pops or fills up to MAX_PREFIX stack entries, and its pops and result
// hand-off can be held off by m_axis_tready. The start stack is a RAM with one write
// port and one read port; it paces the pops and fills at one entry per cycle, unless
// m_axis_tready holds the output. A finish request flushes the whole stack and
// sets the suffix position back to zero. The stack needs no clearing pass after reset.
module lcp_interval_prefix_counter_unit
  import lcpc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [LEN_W-1:0]       cfg_wdata,      // max_len
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // match_len
  input  wire logic                   s_axis_tuser,   // cmd
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // prefix_len, occurrences, end_suffix
  output logic                        m_axis_tlast
);

  lcpc_cmd_t        cmd;
  lcpc_stat_t       stat;
  logic [LEN_W-1:0] out_len;
  logic [CNT_W-1:0] out_occ;
  logic [CNT_W-1:0] out_end;

  lcpc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lcpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (s_axis_tuser),
    .in_len    (s_axis_tdata[LEN_W-1:0]),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_len   (out_len),
    .out_occ   (out_occ),
    .out_end   (out_end),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({out_end, out_occ, out_len});

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the LCP interval prefix counter unit.
`timescale 1ns / 100ps

module tb_top;
  import lcpc_pkg::*;

  localparam longint unsigned POSITION_LIMIT = (64'd1 << INDEX_BITS) - 1;
  localparam int SETTLE_CYCLES = 3 * MAX_PREFIX + 16;

  typedef struct packed {
    logic [LEN_W-1:0] prefix_len;
    logic [CNT_W-1:0] occurrences;
    logic [CNT_W-1:0] end_suffix;
    logic             last;
  } prefix_report_t;

  class prefix_scoreboard;
    logic [LEN_W-1:0] max_len;
    int unsigned      depth;
    longint unsigned  starts[MAX_PREFIX];
    longint unsigned  position;
    prefix_report_t   pending[$];
    int               errors;

    function new();
      max_len  = MAX_LEN_RESET;
      depth    = 0;
      position = 0;
      errors   = 0;
    endfunction

    task report(input string what);
      if (errors < 50)
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void close_intervals(input int unsigned target);
      prefix_report_t held;
      longint unsigned n;
      bit first;
      bit have_held;
      first     = 1'b1;
      have_held = 1'b0;
      while (depth > target) begin
        n = (position >= starts[depth-1]) ? position - starts[depth-1] + 1 : 1;
        if (first || n > 2) begin
          if (have_held)
            pending.push_back(held);
          held.prefix_len  = LEN_W'(depth);
          held.occurrences = (n > 64'hFFFF_FFFF) ? '1 : CNT_W'(n);
          held.end_suffix  = CNT_W'(position - 1);
          held.last        = 1'b0;
          have_held        = 1'b1;
        end
        first = 1'b0;
        depth--;
      end
      if (have_held) begin
        held.last = 1'b1;
        pending.push_back(held);
      end
    endfunction

    function void note_request(input logic cmd, input logic [LEN_W-1:0] len);
      int unsigned eff;
      if (cmd == CMD_FINISH) begin
        close_intervals(0);
        position = 0;
      end else begin
        eff = len;
        if (eff > max_len)
          eff = max_len;
        if (eff > MAX_PREFIX)
          eff = MAX_PREFIX;
        close_intervals(eff);
        while (depth < eff) begin
          starts[depth] = position;
          depth++;
        end
        if (position < POSITION_LIMIT)
          position++;
      end
    endfunction

    task check_result(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
      prefix_report_t want;
      logic [LEN_W-1:0] got_len;
      logic [CNT_W-1:0] got_occ;
      logic [CNT_W-1:0] got_end;
      got_len = data[0 +: LEN_W];
      got_occ = data[LEN_W +: CNT_W];
      got_end = data[LEN_W + CNT_W +: CNT_W];
      if (pending.size() == 0) begin
        report($sformatf("unexpected result len=%0d occ=%0d end=%0d",
                         got_len, got_occ, got_end));
        return;
      end
      want = pending.pop_front();
      if (got_len !== want.prefix_len)
        report($sformatf("prefix_len %0d, want %0d", got_len, want.prefix_len));
      if (got_occ !== want.occurrences)
        report($sformatf("occurrences %0d, want %0d", got_occ, want.occurrences));
      if (got_end !== want.end_suffix)
        report($sformatf("end_suffix %0d, want %0d", got_end, want.end_suffix));
      if (tlast !== want.last)
        report($sformatf("tlast %b, want %b", tlast, want.last));
    endtask
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [LEN_W-1:0]       cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic long_hold   = 1'b0;
  logic rx_idle_on  = 1'b1;
  bit   tx_idle_on  = 1'b1;
  int   rx_gap      = 0;
  int   requests_sent = 0;

  prefix_scoreboard sb;

  lcp_interval_prefix_counter_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    if (rx_gap > 0)
      rx_gap--;
    else if (rx_idle_on && $urandom_range(0, 5) == 0)
      rx_gap = $urandom_range(1, 18);
    m_axis_tready <= !long_hold && (rx_gap == 0);
  end

  task automatic send_request(input logic cmd, input logic [LEN_W-1:0] len);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_TDATA_W'(len);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(cmd, len);
    requests_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_len = value;
  endtask

  // Sorted-suffix walks with a wandering match length, closed by a finish; some noise between.
  task automatic send_texts(input int count);
    int target;
    int top;
    int lvl;
    int n_suffixes;
    target = requests_sent + count;
    top    = (sb.max_len == 0 || sb.max_len > MAX_PREFIX) ? MAX_PREFIX : sb.max_len;
    while (requests_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        n_suffixes = $urandom_range(2, 30);
        lvl = 0;
        for (int i = 0; i < n_suffixes; i++) begin
          send_request(CMD_SUFFIX, LEN_W'(lvl));
          case ($urandom_range(0, 9))
            0:       lvl = 0;
            1:       lvl = $urandom_range(0, 127);
            2, 3:    lvl = $urandom_range(0, top);
            default: begin
              lvl = lvl + $urandom_range(0, 6) - 3;
              if (lvl < 0)
                lvl = 0;
              if (lvl > top + 2)
                lvl = top + 2;
            end
          endcase
        end
        send_request(CMD_FINISH, LEN_W'($urandom_range(0, 127)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(($urandom_range(0, 3) == 0) ? CMD_FINISH : CMD_SUFFIX,
                       LEN_W'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_SUFFIX, 7'd0);
    send_request(CMD_SUFFIX, 7'd64);
    send_request(CMD_SUFFIX, 7'd64);
    send_request(CMD_SUFFIX, 7'd64);
    send_request(CMD_SUFFIX, 7'd3);
    send_request(CMD_SUFFIX, 7'd100);
    send_request(CMD_SUFFIX, 7'd127);
    send_request(CMD_SUFFIX, 7'd63);
    send_request(CMD_SUFFIX, 7'd42);
    send_request(CMD_SUFFIX, 7'd21);
    send_request(CMD_SUFFIX, 7'd0);
    send_request(CMD_SUFFIX, 7'd0);
    send_request(CMD_FINISH, 7'd85);
    send_request(CMD_FINISH, 7'd0);
    send_request(CMD_SUFFIX, 7'd1);
    send_request(CMD_SUFFIX, 7'd2);
    send_request(CMD_SUFFIX, 7'd0);
    send_request(CMD_SUFFIX, 7'd5);
    send_request(CMD_SUFFIX, 7'd5);
    send_request(CMD_SUFFIX, 7'd1);
    send_request(CMD_FINISH, 7'd127);
    settle();

    write_max_len(7'd1);
    send_texts(40);
    settle();

    write_max_len(7'd0);
    send_texts(20);
    settle();

    write_max_len(7'd127);
    send_texts(60);
    settle();

    write_max_len(7'd5);
    send_texts(80);
    settle();

    write_max_len(7'd20);
    send_texts(80);
    settle();

    write_max_len(7'd64);
    fork
      begin
        long_hold <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold <= 1'b0;
      end
      send_texts(120);
    join
    settle();

    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    send_texts(60);
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== lcp_interval_prefix_counter_unit.f =====
rtl/lcpc_pkg.sv
rtl/lcpc_ram.sv
rtl/lcpc_ctrl.sv
rtl/lcpc_dp.sv
rtl/lcp_interval_prefix_counter_unit.sv
verif/tb_top.sv
